/* src/mbsu_pkg.sv */
// ----------------------------------------------------------------------------
// mbsu_pkg
// Shared types and constants of the barrier synchronization unit: register
// window bases and the request kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsu_pkg;

	localparam int OFF_W    = 12;
	localparam int PE_IDX_W = 3;
	localparam int RD_W     = 6;
	localparam int SLOT_W   = 4;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_INIT = 2'd0;
	localparam kind_t KIND_EN   = 2'd1;
	localparam kind_t KIND_CHK  = 2'd2;
	localparam kind_t KIND_SYNC = 2'd3;

	localparam logic [3:0] REG_OFF_LO = 4'h0;
	localparam logic [3:0] REG_OFF_HI = 4'h4;

	localparam logic [3:0] PAGE_CTRL = 4'h0;
	localparam logic [3:0] PAGE_SELF = 4'h1;

endpackage

`default_nettype wire

/* src/multicore_barrier_sync_unit.sv */
// ----------------------------------------------------------------------------
// multicore_barrier_sync_unit
// Hardware barrier: per-channel enable, check and sync bits held in one
// synchronous memory and updated by a read-modify-write per write request.
// The request and the memory read are registered in stage 1, then done and
// read_data in the result register.
// Throughput: one request per cycle; a write forwarded from the previous
// request covers back-to-back accesses to the same channel.
// busy never asserts, and the receiver cannot stall the result.
// Reset clears per-channel valid bits so every channel reads as zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multicore_barrier_sync_unit
	import mbsu_pkg::*;
#(
	parameter int CHANNELS = 16,
	parameter int PES      = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                mode,
	input  wire logic [OFF_W-1:0]    offset,
	input  wire logic [31:0]         write_data,
	input  wire logic [PE_IDX_W-1:0] accessing_pe,
	output logic                     done,
	output logic [RD_W-1:0]          read_data
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EW = 3 * PES;

	typedef struct packed {
		logic [PES-1:0] en;
		logic [PES-1:0] arr;
		logic [PES-1:0] rel;
	} entry_t;

	// Request decode.
	logic                accept;
	logic [SLOT_W-1:0]   slot;
	logic [3:0]          reg_off;
	logic [PE_IDX_W-1:0] dec_pe;
	logic                dec_hole;
	logic                dec_lower;
	kind_t               dec_kind;
	logic [CW-1:0]       dec_ch;

	assign accept  = start && !busy;
	assign busy    = 1'b0;
	assign slot    = offset[7:4];
	assign reg_off = offset[3:0];

	always_comb begin
		dec_hole  = 1'b0;
		dec_lower = 1'b0;
		dec_pe    = '0;
		if (offset[11:8] == PAGE_CTRL) begin
			dec_lower = 1'b1;
		end else if (offset[11:8] == PAGE_SELF) begin
			dec_pe = accessing_pe;
			if (32'(accessing_pe) >= PES) dec_hole = 1'b1;
		end else if (offset[11]) begin
			dec_pe = offset[10:8];
			if (32'(offset[10:8]) >= PES) dec_hole = 1'b1;
		end else begin
			dec_hole = 1'b1;
		end
		if (32'(slot) >= CHANNELS) dec_hole = 1'b1;
		if (reg_off != REG_OFF_LO && reg_off != REG_OFF_HI) dec_hole = 1'b1;
		if (dec_lower) begin
			dec_kind = (reg_off == REG_OFF_LO) ? KIND_INIT : KIND_EN;
		end else begin
			dec_kind = (reg_off == REG_OFF_LO) ? KIND_CHK : KIND_SYNC;
		end
		dec_ch = slot[CW-1:0];
	end

	// Stage 1 request registers.
	logic                vld_s1;
	logic                mode_s1;
	logic                hole_s1;
	kind_t               kind_s1;
	logic [CW-1:0]       ch_s1;
	logic [PE_IDX_W-1:0] pe_s1;
	logic [PES-1:0]      wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			hole_s1  <= dec_hole;
			kind_s1  <= dec_kind;
			ch_s1    <= dec_ch;
			pe_s1    <= dec_pe;
			wdata_s1 <= write_data[PES-1:0];
		end
	end

	// Channel state memory.
	logic [EW-1:0]       mem_q [CHANNELS];
	logic [EW-1:0]       rd_s1;
	logic [CHANNELS-1:0] ent_vld_q;
	logic                wr_en;
	entry_t              wr_data;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem_q[dec_ch];
		end
		if (wr_en) begin
			mem_q[ch_s1] <= wr_data;
		end
	end

	// Forward of the write made at the edge that launched the current read.
	logic          fwd_vld_q;
	logic [CW-1:0] fwd_ch_q;
	entry_t        fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= wr_en;
			if (wr_en) ent_vld_q[ch_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_ch_q   <= ch_s1;
			fwd_data_q <= wr_data;
		end
	end

	// Read-modify-write.
	entry_t         cur;
	logic [PES-1:0] pe_bit;
	logic [PES-1:0] arr_n;
	logic [PES-1:0] rel_n;
	logic [PES-1:0] en_n;
	logic           test;
	logic [7:0]     rd_wide;
	logic [PES-1:0] arr_sh;
	logic [PES-1:0] rel_sh;

	always_comb begin
		if (fwd_vld_q && fwd_ch_q == ch_s1) begin
			cur = fwd_data_q;
		end else if (ent_vld_q[ch_s1]) begin
			cur = entry_t'(rd_s1);
		end else begin
			cur = '0;
		end
		pe_bit = PES'(1) << pe_s1;
		arr_sh = cur.arr >> pe_s1;
		rel_sh = cur.rel >> pe_s1;
		en_n   = cur.en;
		arr_n  = cur.arr;
		rel_n  = cur.rel;
		test   = 1'b0;
		case (kind_s1)
			KIND_INIT: begin
				if (wdata_s1[0]) begin
					arr_n = '0;
					rel_n = '0;
				end
			end
			KIND_EN: begin
				en_n = wdata_s1;
				test = 1'b1;
			end
			KIND_CHK: begin
				if (cur.en != '0) begin
					arr_n = cur.arr | pe_bit;
					test  = 1'b1;
				end
			end
			KIND_SYNC: begin
				rel_n = wdata_s1[0] ? (cur.rel | pe_bit) : (cur.rel & ~pe_bit);
			end
			default: begin
				test = 1'b0;
			end
		endcase
		if (test && en_n != '0 && (arr_n & en_n) == en_n) begin
			arr_n = arr_n & ~en_n;
			rel_n = rel_n | en_n;
		end
		wr_en       = vld_s1 && mode_s1 && !hole_s1;
		wr_data.en  = en_n;
		wr_data.arr = arr_n;
		wr_data.rel = rel_n;

		rd_wide = '0;
		if (!mode_s1 && !hole_s1) begin
			case (kind_s1)
				KIND_EN:   rd_wide = 8'(cur.en);
				KIND_CHK:  rd_wide = {7'd0, arr_sh[0]};
				KIND_SYNC: rd_wide = {7'd0, rel_sh[0]};
				default:   rd_wide = '0;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			read_data <= rd_wide[RD_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the barrier synchronization unit. A queue of bus requests
// (directed cases, then barrier rounds mixed with random noise) drives the
// block. Each accepted request is predicted against a local copy of the
// enable, check and sync bits, and every read_data strobe is compared in
// order with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import mbsu_pkg::*;

	localparam int CHANNELS   = 16;
	localparam int PES        = 6;
	localparam int RAND_ITEMS = 800;
	localparam int STALL_MAX  = 2000;
	localparam bit MODE_RD    = 1'b0;
	localparam bit MODE_WR    = 1'b1;

	typedef struct {
		bit                mode;
		bit [OFF_W-1:0]    offset;
		bit [31:0]         wdata;
		bit [PE_IDX_W-1:0] pe;
		bit                drain;
	} access_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                mode;
	logic [OFF_W-1:0]    offset;
	logic [31:0]         write_data;
	logic [PE_IDX_W-1:0] accessing_pe;
	logic                done;
	logic [RD_W-1:0]     read_data;

	access_t         pending_q[$];
	bit [RD_W-1:0]   read_data_q[$];
	access_t         cur;
	bit [PES-1:0]    en_mask[CHANNELS];
	bit [PES-1:0]    arrived[CHANNELS];
	bit [PES-1:0]    released[CHANNELS];
	int              n_issued;
	int              n_seen;
	int              err_count;
	int              stall_cycles;
	bit              drain_next;
	bit              took;
	bit              go;
	bit [RD_W-1:0]   want;

	multicore_barrier_sync_unit #(
		.CHANNELS(CHANNELS),
		.PES(PES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.offset(offset),
		.write_data(write_data),
		.accessing_pe(accessing_pe),
		.done(done),
		.read_data(read_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit decode_access(input bit [OFF_W-1:0] off,
			input bit [PE_IDX_W-1:0] self, output int ch, output int pe,
			output kind_t kind);
		bit       lower;
		bit [3:0] slot;
		bit [3:0] r;
		ch = 0;
		pe = 0;
		kind = KIND_INIT;
		lower = 1'b0;
		if (off[11:8] == PAGE_CTRL) begin
			lower = 1'b1;
		end else if (off[11:8] == PAGE_SELF) begin
			if (int'(self) >= PES)
				return 1'b0;
			pe = int'(self);
		end else if (off[11]) begin
			if (int'(off[10:8]) >= PES)
				return 1'b0;
			pe = int'(off[10:8]);
		end else begin
			return 1'b0;
		end
		slot = off[7:4];
		r = off[3:0];
		if (int'(slot) >= CHANNELS || (r != REG_OFF_LO && r != REG_OFF_HI))
			return 1'b0;
		ch = int'(slot);
		if (lower)
			kind = (r == REG_OFF_LO) ? KIND_INIT : KIND_EN;
		else
			kind = (r == REG_OFF_LO) ? KIND_CHK : KIND_SYNC;
		return 1'b1;
	endfunction

	// A channel releases when at least one PE is enabled and every enabled PE has checked in.
	function automatic void settle_barrier(input int ch);
		if (en_mask[ch] != '0 && (arrived[ch] & en_mask[ch]) == en_mask[ch]) begin
			arrived[ch] = arrived[ch] & ~en_mask[ch];
			released[ch] = released[ch] | en_mask[ch];
		end
	endfunction

	function automatic bit [RD_W-1:0] predict_access(input access_t a);
		int            ch;
		int            pe;
		kind_t         kind;
		bit [RD_W-1:0] rd;
		bit [PES-1:0]  pe_bit;
		rd = '0;
		if (decode_access(a.offset, a.pe, ch, pe, kind)) begin
			pe_bit = PES'(1) << pe;
			if (a.mode == MODE_RD) begin
				case (kind)
					KIND_EN: rd = RD_W'(en_mask[ch]);
					KIND_CHK: rd = RD_W'(arrived[ch][pe]);
					KIND_SYNC: rd = RD_W'(released[ch][pe]);
					default: rd = '0;
				endcase
			end else begin
				case (kind)
					KIND_INIT: begin
						if (a.wdata[0]) begin
							arrived[ch] = '0;
							released[ch] = '0;
						end
					end
					KIND_EN: begin
						en_mask[ch] = a.wdata[PES-1:0];
						settle_barrier(ch);
					end
					KIND_CHK: begin
						if (en_mask[ch] != '0) begin
							arrived[ch] = arrived[ch] | pe_bit;
							settle_barrier(ch);
						end
					end
					default: begin
						if (a.wdata[0])
							released[ch] = released[ch] | pe_bit;
						else
							released[ch] = released[ch] & ~pe_bit;
					end
				endcase
			end
		end
		return rd;
	endfunction

	function automatic void note_mismatch(input string what, input bit [RD_W-1:0] exp_v,
			input logic [RD_W-1:0] got_v);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s: expected read_data %0h, got %0h", what, exp_v, got_v);
	endfunction

	task automatic add_access(input bit m, input bit [OFF_W-1:0] off, input bit [31:0] wd,
			input bit [PE_IDX_W-1:0] pe);
		access_t a;
		a.mode = m;
		a.offset = off;
		a.wdata = wd;
		a.pe = pe;
		a.drain = drain_next;
		drain_next = 1'b0;
		pending_q.push_back(a);
	endtask

	task automatic add_noise();
		add_access(1'($urandom), 12'($urandom), $urandom, 3'($urandom_range(0, 7)));
	endtask

	// Check-in, sync write or status read of one PE, through its own page or its window.
	task automatic add_pe_access(input bit m, input int ch, input int pe,
			input bit [3:0] r, input bit [31:0] wd);
		if ($urandom_range(0, 1) == 0)
			add_access(m, {PAGE_SELF, 4'(ch), r}, wd, 3'(pe));
		else
			add_access(m, {1'b1, 3'(pe), 4'(ch), r}, wd, 3'($urandom_range(0, 7)));
	endtask

	task automatic add_barrier_round();
		int           ch;
		int           pe;
		int           tries;
		bit [PES-1:0] mask;
		bit [PES-1:0] came;
		bit [31:0]    wd;
		ch = $urandom_range(0, CHANNELS - 1);
		mask = ($urandom_range(0, 9) == 0) ? '0 : PES'($urandom_range(1, 63));
		if ($urandom_range(0, 9) < 3) begin
			wd = $urandom;
			wd[0] = 1'b1;
			add_access(MODE_WR, {PAGE_CTRL, 4'(ch), REG_OFF_LO}, wd, 3'($urandom_range(0, 7)));
		end
		wd = $urandom;
		wd[PES-1:0] = mask;
		add_access(MODE_WR, {PAGE_CTRL, 4'(ch), REG_OFF_HI}, wd, 3'($urandom_range(0, 7)));
		came = '0;
		tries = 0;
		while (tries < 3 || ((came & mask) != mask && tries < 24)) begin
			pe = $urandom_range(0, PES - 1);
			add_pe_access(MODE_WR, ch, pe, REG_OFF_LO, $urandom);
			came[pe] = 1'b1;
			tries++;
			if ($urandom_range(0, 9) < 3)
				add_pe_access(MODE_RD, ch, $urandom_range(0, PES - 1),
					($urandom_range(0, 1) == 0) ? REG_OFF_LO : REG_OFF_HI, $urandom);
			if ($urandom_range(0, 9) == 0)
				add_noise();
		end
		add_access(MODE_RD, {PAGE_CTRL, 4'(ch), REG_OFF_HI}, $urandom, 3'($urandom_range(0, 7)));
		for (int i = 0; i < 2; i++)
			add_pe_access(MODE_RD, ch, $urandom_range(0, PES - 1), REG_OFF_HI, $urandom);
		if ($urandom_range(0, 3) == 0)
			add_pe_access(MODE_WR, ch, $urandom_range(0, PES - 1), REG_OFF_HI, $urandom);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= 1'b0;
			offset <= '0;
			write_data <= '0;
			accessing_pe <= '0;
			n_issued <= 0;
		end else begin
			took = start && !busy;
			if (took) begin
				read_data_q.push_back(predict_access(cur));
				n_issued <= n_issued + 1;
			end
			go = 1'b0;
			if (!start || took) begin
				go = pending_q.size() != 0;
				if (go && pending_q[0].drain && (took || n_issued != n_seen))
					go = 1'b0;
				if (go && !(n_issued >= 300 && n_issued < 500) && $urandom_range(0, 99) < 10)
					go = 1'b0;
			end
			if (go) begin
				cur = pending_q.pop_front();
				mode <= cur.mode;
				offset <= cur.offset;
				write_data <= cur.wdata;
				accessing_pe <= cur.pe;
				start <= 1'b1;
			end else if (took) begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_seen <= 0;
		end else if (done) begin
			n_seen <= n_seen + 1;
			if (read_data_q.size() == 0) begin
				note_mismatch("result with no request pending", '0, read_data);
			end else begin
				want = read_data_q.pop_front();
				if (read_data !== want)
					note_mismatch("read_data", want, read_data);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		err_count = 0;
		drain_next = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			en_mask[i] = '0;
			arrived[i] = '0;
			released[i] = '0;
		end

		add_access(MODE_RD, 12'h004, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h014, 32'hFFFF_FFC0, 3'd7);
		add_access(MODE_WR, 12'h110, 32'hFFFF_FFFF, 3'd0);
		add_access(MODE_RD, 12'h110, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h004, 32'h0000_0005, 3'd3);
		add_access(MODE_WR, 12'h100, 32'h0, 3'd1);
		add_access(MODE_WR, 12'h800, 32'h0, 3'd5);
		add_access(MODE_RD, 12'h900, 32'h0, 3'd4);
		add_access(MODE_WR, 12'h100, 32'h1234_5678, 3'd2);
		add_access(MODE_RD, 12'hA04, 32'h0, 3'd0);
		add_access(MODE_RD, 12'h104, 32'h0, 3'd1);
		add_access(MODE_WR, 12'h104, 32'hFFFF_FFFE, 3'd2);
		add_access(MODE_WR, 12'h0F4, 32'hFFFF_FFFF, 3'd0);
		add_access(MODE_RD, 12'h0F4, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h000, 32'hFFFF_FFFE, 3'd0);
		add_access(MODE_RD, 12'h000, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h000, 32'h0000_0001, 3'd0);
		add_access(MODE_WR, 12'h200, 32'hFFFF_FFFF, 3'd0);
		add_access(MODE_RD, 12'h7FC, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h008, 32'hFFFF_FFFF, 3'd0);
		add_access(MODE_RD, 12'hE00, 32'h0, 3'd0);
		add_access(MODE_WR, 12'hFFF, 32'hFFFF_FFFF, 3'd7);
		add_access(MODE_WR, 12'h100, 32'h0, 3'd6);
		add_access(MODE_RD, 12'h104, 32'h0, 3'd7);
		add_access(MODE_WR, 12'h024, 32'h0000_0003, 3'd0);
		add_access(MODE_WR, 12'h820, 32'h0, 3'd0);
		add_access(MODE_WR, 12'h024, 32'h0000_0001, 3'd0);
		add_access(MODE_RD, 12'h824, 32'h0, 3'd0);
		drain_next = 1'b1;

		while (pending_q.size() < RAND_ITEMS + 28) begin
			if ($urandom_range(0, 99) < 15)
				add_noise();
			else
				add_barrier_round();
			if ($urandom_range(0, 29) == 0)
				drain_next = 1'b1;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || start)
			@(posedge clk);
		while (n_seen < n_issued)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (read_data_q.size() != 0)
			note_mismatch("request with no result", read_data_q[0], 'x);

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* multicore_barrier_sync_unit.f */
src/mbsu_pkg.sv
src/multicore_barrier_sync_unit.sv
tb/tb.sv
